FILE: sv/mrrs_pkg.sv
// Shared types and constants for the multicore round-robin scheduler.
// Used by every module of the block; depends on nothing else.
package mrrs_pkg;

	localparam int NUM_CORES   = 4;
	localparam int QUEUE_DEPTH = 16;
	localparam int NUM_QREGS   = 4;

	localparam int TID_W     = 8;
	localparam int OP_W      = 3;
	localparam int CORE_W    = 2;
	localparam int QUANT_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int POS_W     = $clog2(QUEUE_DEPTH);
	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
	localparam logic [OP_W-1:0] OP_UNBLOCK = 3'd1;
	localparam logic [OP_W-1:0] OP_TICK    = 3'd2;
	localparam logic [OP_W-1:0] OP_BLOCK   = 3'd3;
	localparam logic [OP_W-1:0] OP_EXIT    = 3'd4;

	localparam logic [QUANT_W-1:0] QUANT_RESET = 16'd10;

	typedef struct packed {
		logic [TID_W-1:0] tid;
		logic             blk;
	} entry_t;

	// one command for the whole row of queue cells
	typedef struct packed {
		logic             shift;
		logic             ins_en;
		logic [POS_W-1:0] ins_pos;
		entry_t           ins;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_UNB,
		S_DISP
	} state_t;

endpackage

FILE: sv/mrrs_cell.sv
// One slot of the wait queue: holds an entry, loads an insert aimed at its index, and
// otherwise takes its right neighbour's entry on a shift. Depends on mrrs_pkg.
module mrrs_cell (
	input  logic                       clk,
	input  logic [mrrs_pkg::POS_W-1:0] idx,
	input  mrrs_pkg::cell_ctrl_t       ctrl,
	input  mrrs_pkg::entry_t           right,
	output mrrs_pkg::entry_t           ent
);

	mrrs_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins_en && (ctrl.ins_pos == idx)) begin
			entry_q <= ctrl.ins;
		end else if (ctrl.shift) begin
			entry_q <= right;
		end
	end

	assign ent = entry_q;

endmodule

FILE: sv/mrrs_seq.sv
// Sequencer of the scheduler: accepts beats, steps the queue row, keeps per-core state
// and the result register. Depends on mrrs_pkg.
module mrrs_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [mrrs_pkg::OP_W-1:0]    opcode,
	input  logic [mrrs_pkg::TID_W-1:0]   task_id,
	input  logic [mrrs_pkg::CORE_W-1:0]  core,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [mrrs_pkg::TID_W-1:0]   next_task,
	output logic                         run_idle,
	output logic                         load_dropped,
	input  logic                         cfg_we,
	input  logic [mrrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mrrs_pkg::QUANT_W-1:0] cfg_data,
	input  mrrs_pkg::entry_t             front,
	output mrrs_pkg::cell_ctrl_t         cctl
);

	localparam int CNT_W  = mrrs_pkg::CNT_W;
	localparam int POS_W  = mrrs_pkg::POS_W;
	localparam int QW     = mrrs_pkg::QUANT_W;
	localparam int TW     = mrrs_pkg::TID_W;

	mrrs_pkg::state_t state_q, state_d;

	logic [mrrs_pkg::OP_W-1:0]   op_q;
	logic [TW-1:0]               tid_q;
	logic [mrrs_pkg::CORE_W-1:0] core_q;
	logic [CNT_W-1:0]            cnt_q, cnt_d, step_q, step_d;
	logic                        found_q, found_d;

	logic [QW-1:0] quant_q [mrrs_pkg::NUM_QREGS];
	logic [QW-1:0] qleft_q [mrrs_pkg::NUM_CORES];
	logic [TW-1:0] rtid_q  [mrrs_pkg::NUM_CORES];
	logic          ridle_q [mrrs_pkg::NUM_CORES];

	logic          accept, out_free, core_we, out_load;
	logic [QW-1:0] qleft_d, qdec, qdec_in;
	logic [TW-1:0] rtid_d;
	logic          ridle_d, drop_d, need_find, ready, requeue;
	logic [CNT_W-1:0] cnt_m1;

	assign in_stall = (state_q != mrrs_pkg::S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign cnt_m1   = cnt_q - CNT_W'(1);

	assign qdec_in = (qleft_q[core] == '0) ? '0 : qleft_q[core] - QW'(1);
	assign qdec    = (qleft_q[core_q] == '0) ? '0 : qleft_q[core_q] - QW'(1);
	assign need_find = (opcode != mrrs_pkg::OP_TICK) || ridle_q[core] || (qdec_in == '0);
	assign ready   = (step_q < cnt_q);
	assign requeue = (op_q == mrrs_pkg::OP_BLOCK) && !ridle_q[core_q];

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		step_d   = step_q;
		found_d  = found_q;
		cctl     = '0;
		core_we  = 1'b0;
		out_load = 1'b0;
		drop_d   = 1'b0;
		qleft_d  = qdec;
		rtid_d   = rtid_q[core_q];
		ridle_d  = ridle_q[core_q];
		unique case (state_q)
			mrrs_pkg::S_IDLE: begin
				if (in_valid) begin
					priority if (opcode == mrrs_pkg::OP_LOAD) begin
						state_d = mrrs_pkg::S_LOAD;
					end else if (opcode == mrrs_pkg::OP_UNBLOCK) begin
						state_d = mrrs_pkg::S_UNB;
						step_d  = cnt_q;
						found_d = 1'b0;
					end else if ((opcode == mrrs_pkg::OP_TICK || opcode == mrrs_pkg::OP_BLOCK
							|| opcode == mrrs_pkg::OP_EXIT)
							&& ({1'b0, core} < (mrrs_pkg::CORE_W + 1)'(mrrs_pkg::NUM_CORES))) begin
						state_d = mrrs_pkg::S_DISP;
						// no search: start past the end so nothing reads as ready
						step_d  = need_find ? '0 : cnt_q;
					end else begin
						state_d = mrrs_pkg::S_IDLE;
					end
				end
			end
			mrrs_pkg::S_LOAD: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = mrrs_pkg::S_IDLE;
					if (cnt_q < CNT_W'(mrrs_pkg::QUEUE_DEPTH)) begin
						cctl.ins_en  = 1'b1;
						cctl.ins_pos = cnt_q[POS_W-1:0];
						cctl.ins     = '{tid: tid_q, blk: 1'b0};
						cnt_d        = cnt_q + CNT_W'(1);
					end else begin
						drop_d = 1'b1;
					end
				end
			end
			mrrs_pkg::S_UNB: begin
				if (step_q != '0) begin
					// rotate the front out; keep it unless it is the task being unblocked
					cctl.shift = 1'b1;
					step_d     = step_q - CNT_W'(1);
					if (front.tid != tid_q) begin
						cctl.ins_en  = 1'b1;
						cctl.ins_pos = cnt_m1[POS_W-1:0];
						cctl.ins     = front;
					end else begin
						cnt_d   = cnt_m1;
						found_d = 1'b1;
					end
				end else begin
					state_d = mrrs_pkg::S_IDLE;
					if (found_q) begin
						cctl.ins_en  = 1'b1;
						cctl.ins_pos = cnt_q[POS_W-1:0];
						cctl.ins     = '{tid: tid_q, blk: 1'b0};
						cnt_d        = cnt_q + CNT_W'(1);
					end
				end
			end
			mrrs_pkg::S_DISP: begin
				if (ready && front.blk) begin
					// move a blocked front entry to the back
					cctl.shift   = 1'b1;
					cctl.ins_en  = 1'b1;
					cctl.ins_pos = cnt_m1[POS_W-1:0];
					cctl.ins     = '{tid: front.tid, blk: 1'b1};
					step_d       = step_q + CNT_W'(1);
				end else if (out_free) begin
					core_we  = 1'b1;
					out_load = 1'b1;
					state_d  = mrrs_pkg::S_IDLE;
					if (op_q != mrrs_pkg::OP_TICK) begin
						qleft_d = quant_q[core_q];
						ridle_d = !ready;
						rtid_d  = front.tid;
						if (ready && requeue) begin
							cctl.shift   = 1'b1;
							cctl.ins_en  = 1'b1;
							cctl.ins_pos = cnt_m1[POS_W-1:0];
							cctl.ins     = '{tid: rtid_q[core_q], blk: 1'b1};
						end else if (ready) begin
							cctl.shift = 1'b1;
							cnt_d      = cnt_m1;
						end else if (requeue && (cnt_q < CNT_W'(mrrs_pkg::QUEUE_DEPTH))) begin
							cctl.ins_en  = 1'b1;
							cctl.ins_pos = cnt_q[POS_W-1:0];
							cctl.ins     = '{tid: rtid_q[core_q], blk: 1'b1};
							cnt_d        = cnt_q + CNT_W'(1);
						end
					end else if (ridle_q[core_q]) begin
						if (ready) begin
							qleft_d    = quant_q[core_q];
							rtid_d     = front.tid;
							ridle_d    = 1'b0;
							cctl.shift = 1'b1;
							cnt_d      = cnt_m1;
						end
					end else if (qdec == '0) begin
						qleft_d = quant_q[core_q];
						if (ready) begin
							// swap: dispatch the front, requeue the preempted task as ready
							rtid_d       = front.tid;
							cctl.shift   = 1'b1;
							cctl.ins_en  = 1'b1;
							cctl.ins_pos = cnt_m1[POS_W-1:0];
							cctl.ins     = '{tid: rtid_q[core_q], blk: 1'b0};
						end
					end
					if (ridle_d) begin
						rtid_d = '0;
					end
				end
			end
			default: state_d = mrrs_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mrrs_pkg::S_IDLE;
			cnt_q     <= '0;
			step_q    <= '0;
			found_q   <= 1'b0;
			out_valid <= 1'b0;
			for (int i = 0; i < mrrs_pkg::NUM_QREGS; i++) begin
				quant_q[i] <= mrrs_pkg::QUANT_RESET;
			end
			for (int i = 0; i < mrrs_pkg::NUM_CORES; i++) begin
				qleft_q[i] <= '0;
				rtid_q[i]  <= '0;
				ridle_q[i] <= 1'b1;
			end
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			step_q  <= step_d;
			found_q <= found_d;
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			if (cfg_we) begin
				quant_q[cfg_index] <= cfg_data;
			end
			if (core_we) begin
				qleft_q[core_q] <= qleft_d;
				rtid_q[core_q]  <= rtid_d;
				ridle_q[core_q] <= ridle_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			tid_q  <= task_id;
			core_q <= core;
		end
		if (out_load) begin
			next_task    <= (op_q == mrrs_pkg::OP_LOAD) ? '0 : rtid_d;
			run_idle     <= (op_q == mrrs_pkg::OP_LOAD) ? 1'b0 : ridle_d;
			load_dropped <= drop_d;
		end
	end

endmodule

FILE: sv/multicore_round_robin_scheduler.sv
// Multicore round-robin scheduler: four cores share one circular wait queue.
// Channels: an input beat (opcode, task_id, core) with in_valid/in_stall and a result beat
// (next_task, run_idle, load_dropped) with out_valid/out_stall. A load gives one result with
// only load_dropped meaningful; an unblock gives none; tick, block and exit give the core's
// next task, or run_idle with next_task zero. Unknown opcodes are taken and ignored.
// The queue is a row of sixteen cells; every rotation step moves each entry one cell
// towards the front, and the sequencer only looks at the front cell.
// One beat at a time. An unblock rotates each queued entry once, dropping the unblocked
// task, then appends it if found; tick, block and exit, when searching, first rotate each
// blocked front entry to the back. The user writes the quantum registers through
// cfg_we/cfg_index/cfg_data only while no beat is in work; the block does not enforce it.
// Reset: queue empty, every core idle, quanta at 10, countdowns at zero. Queue cells have
// no reset; only entries written since are ever read.
// While out_stall holds a result, the block keeps the result and finishes its next load,
// tick, block or exit beat only once the result register is free.
// Depends on mrrs_pkg, mrrs_cell and mrrs_seq.
module multicore_round_robin_scheduler (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [mrrs_pkg::OP_W-1:0]      opcode,
	input  logic [mrrs_pkg::TID_W-1:0]     task_id,
	input  logic [mrrs_pkg::CORE_W-1:0]    core,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [mrrs_pkg::TID_W-1:0]     next_task,
	output logic                           run_idle,
	output logic                           load_dropped,
	input  logic                           cfg_we,
	input  logic [mrrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mrrs_pkg::QUANT_W-1:0]   cfg_data
);

	mrrs_pkg::cell_ctrl_t cctl;
	mrrs_pkg::entry_t     ent [mrrs_pkg::QUEUE_DEPTH];

	mrrs_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.task_id      (task_id),
		.core         (core),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.next_task    (next_task),
		.run_idle     (run_idle),
		.load_dropped (load_dropped),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.front        (ent[0]),
		.cctl         (cctl)
	);

	for (genvar i = 0; i < mrrs_pkg::QUEUE_DEPTH; i++) begin : g_cell
		mrrs_pkg::entry_t right;
		if (i == mrrs_pkg::QUEUE_DEPTH - 1) begin : g_last
			assign right = ent[i];
		end else begin : g_mid
			assign right = ent[i+1];
		end
		mrrs_cell u_cell (
			.clk   (clk),
			.idx   (mrrs_pkg::POS_W'(i)),
			.ctrl  (cctl),
			.right (right),
			.ent   (ent[i])
		);
	end

endmodule

FILE: sv/mrrs_checker.sv
// Port-level checks for the scheduler, bound to the top level.
// Depends on mrrs_pkg and multicore_round_robin_scheduler.
module mrrs_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic [mrrs_pkg::OP_W-1:0]    opcode,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [mrrs_pkg::TID_W-1:0]   next_task,
	input logic                         run_idle,
	input logic                         load_dropped
);

	// an accepted load always leaves the block busy, with in_stall raised
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (opcode == mrrs_pkg::OP_LOAD) |=> in_stall)
		else $error("load beat accepted but block not busy");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_idle |-> (next_task == '0) && !load_dropped)
		else $error("idle result carries a task or a drop flag");

	a_drop_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && load_dropped |-> (next_task == '0) && !run_idle)
		else $error("dropped load result carries a task");

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(next_task) && $stable(run_idle)
			&& $stable(load_dropped))
		else $error("stalled result beat changed");

endmodule

bind multicore_round_robin_scheduler mrrs_checker u_mrrs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.opcode       (opcode),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.next_task    (next_task),
	.run_idle     (run_idle),
	.load_dropped (load_dropped)
);
